// ===== sv/collision_time_predictor_defines.svh =====
// assertion macros for the collision time predictor
`ifndef COLLISION_TIME_PREDICTOR_DEFINES_SVH
`define COLLISION_TIME_PREDICTOR_DEFINES_SVH

// property that holds at every edge outside reset
`define CTP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent now, consequent after the delay given by n
`define CTP_ASSERT_LATER(lbl, clk, rst_n, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== sv/ctp_pkg.sv =====
`timescale 1ns / 1ps

package ctp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int IN_W       = 32;
  localparam int RAD_W      = 31;
  localparam int TIME_W     = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // pair path widths
  localparam int DIFF_W  = IN_W + 1;
  localparam int SIG_W   = RAD_W + 1;
  localparam int SPROD_W = 2 * DIFF_W;
  localparam int DOT_W   = SPROD_W + 1;
  localparam int SQR_W   = 2 * IN_W;
  localparam int SS_W    = 2 * SIG_W;
  localparam int MAG_W   = 2 * IN_W + 1;
  localparam int SPLIT   = (MAG_W + 1) / 2;
  localparam int PP_W    = 2 * SPLIT;
  localparam int WIDE_W  = 2 * MAG_W;
  localparam int ACC_W   = WIDE_W + 1;
  localparam int RADC_W  = ACC_W + 1;
  localparam int SQ_N    = RADC_W / 2;
  localparam int ROOT_W  = SQ_N;
  localparam int SREM_W  = ROOT_W + 1;
  localparam int DV_N    = ROOT_W + FRAC_BITS;
  localparam int DREM_W  = MAG_W;
  localparam int MAGQ_W  = 64;

  // wall path widths
  localparam int WNUM_W = IN_W + 3;
  localparam int WMAG_W = IN_W + 1;
  localparam int WDIV_W = IN_W;
  localparam int WD_N   = WMAG_W + FRAC_BITS;

  // register stages from accept to result
  localparam int PIPE_DEPTH = 8 + SQ_N + 1 + DV_N + 1;
  localparam int WL_N       = PIPE_DEPTH - 1 - WD_N;

  localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

  localparam logic [RAD_W-1:0] BOX_RESET = RAD_W'(longint'(882) << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_WIDTH,
    REG_BOX_HEIGHT
  } cfg_reg_e;

endpackage

// ===== sv/collision_time_predictor.sv =====
`timescale 1ns / 1ps

// Predicts, for a pair of disks, the time until they touch and the times until disk A
// meets a vertical and a horizontal wall of the box. One pair is taken every clock
// cycle: busy stays low, so start is always taken. Each result shows on the result
// ports for one cycle with result_valid_o high, in the order the starts were taken; the
// receiver cannot hold results off and must take every beat as it comes. The latency
// is set by the 66-step square root of the discriminant and the 82-step divider for
// the contact time, each one step per pipeline register. Box size registers may be
// written while no item is in flight; cfg_ready_o is always high.
module collision_time_predictor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ctp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                same_particle_i,
  input  logic signed [ctp_pkg::IN_W-1:0]     pos_x_a_i,
  input  logic signed [ctp_pkg::IN_W-1:0]     pos_y_a_i,
  input  logic signed [ctp_pkg::IN_W-1:0]     vel_x_a_i,
  input  logic signed [ctp_pkg::IN_W-1:0]     vel_y_a_i,
  input  logic [ctp_pkg::RAD_W-1:0]           radius_a_i,
  input  logic signed [ctp_pkg::IN_W-1:0]     pos_x_b_i,
  input  logic signed [ctp_pkg::IN_W-1:0]     pos_y_b_i,
  input  logic signed [ctp_pkg::IN_W-1:0]     vel_x_b_i,
  input  logic signed [ctp_pkg::IN_W-1:0]     vel_y_b_i,
  input  logic [ctp_pkg::RAD_W-1:0]           radius_b_i,
  output logic                                result_valid_o,
  output logic                                pair_hit_o,
  output logic signed [ctp_pkg::TIME_W-1:0]   pair_time_o,
  output logic                                vwall_hit_o,
  output logic signed [ctp_pkg::TIME_W-1:0]   vwall_time_o,
  output logic                                hwall_hit_o,
  output logic signed [ctp_pkg::TIME_W-1:0]   hwall_time_o
);
  import ctp_pkg::*;

  typedef struct packed {
    logic                     same;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dvx;
    logic signed [DIFF_W-1:0] dvy;
    logic [SIG_W-1:0]         sig;
  } s1_t;

  typedef struct packed {
    logic                      same;
    logic signed [SPROD_W-1:0] rv_x;
    logic signed [SPROD_W-1:0] rv_y;
    logic [SQR_W-1:0]          vv_x;
    logic [SQR_W-1:0]          vv_y;
    logic [SQR_W-1:0]          rr_x;
    logic [SQR_W-1:0]          rr_y;
    logic [SS_W-1:0]           ss;
  } s2_t;

  typedef struct packed {
    logic                    nohit;
    logic signed [DOT_W-1:0] dvdr;
    logic [MAG_W-1:0]        dvdv;
    logic [MAG_W-1:0]        drdr;
    logic [SS_W-1:0]         ss;
  } s3_t;

  typedef struct packed {
    logic             nohit;
    logic [MAG_W-1:0] mdr;
    logic [MAG_W-1:0] dvdv;
    logic [MAG_W-1:0] drdr;
    logic [SS_W-1:0]  ss;
  } s4_t;

  typedef struct packed {
    logic [PP_W-1:0] ll;
    logic [PP_W-1:0] lh;
    logic [PP_W-1:0] hl;
    logic [PP_W-1:0] hh;
  } pp_t;

  typedef struct packed {
    logic             nohit;
    logic [MAG_W-1:0] mdr;
    logic [MAG_W-1:0] dvdv;
    pp_t              pa;
    pp_t              pb;
    pp_t              pc;
  } s5_t;

  typedef struct packed {
    logic              nohit;
    logic [MAG_W-1:0]  mdr;
    logic [MAG_W-1:0]  dvdv;
    logic [WIDE_W-1:0] pa;
    logic [WIDE_W-1:0] pb;
    logic [WIDE_W-1:0] pc;
  } s6_t;

  typedef struct packed {
    logic              nohit;
    logic [MAG_W-1:0]  mdr;
    logic [MAG_W-1:0]  dvdv;
    logic [ACC_W-1:0]  a;
    logic [WIDE_W-1:0] b;
  } s7_t;

  typedef struct packed {
    logic              nohit;
    logic [MAG_W-1:0]  mdr;
    logic [MAG_W-1:0]  dvdv;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [RADC_W-1:0] rad;
  } sq_t;

  typedef struct packed {
    logic              nohit;
    logic              nneg;
    logic [MAG_W-1:0]  dvdv;
    logic [DREM_W-1:0] rem;
    logic [DV_N-1:0]   nq;
  } dv_t;

  typedef struct packed {
    logic              hit;
    logic              neg;
    logic [WDIV_W-1:0] div;
    logic [WDIV_W-1:0] rem;
    logic [WD_N-1:0]   nq;
  } ax_t;

  typedef struct packed {
    ax_t x;
    ax_t y;
  } wd_t;

  typedef struct packed {
    logic              xhit;
    logic [TIME_W-1:0] xtime;
    logic              yhit;
    logic [TIME_W-1:0] ytime;
  } wo_t;

  function automatic pp_t pp_mul(input logic [MAG_W-1:0] x, input logic [MAG_W-1:0] y);
    pp_t                    r;
    logic [SPLIT-1:0]       xl;
    logic [SPLIT-1:0]       yl;
    logic [MAG_W-SPLIT-1:0] xh;
    logic [MAG_W-SPLIT-1:0] yh;
    xl   = x[SPLIT-1:0];
    yl   = y[SPLIT-1:0];
    xh   = x[MAG_W-1:SPLIT];
    yh   = y[MAG_W-1:SPLIT];
    r.ll = PP_W'(xl) * PP_W'(yl);
    r.lh = PP_W'(xl) * PP_W'(yh);
    r.hl = PP_W'(xh) * PP_W'(yl);
    r.hh = PP_W'(xh) * PP_W'(yh);
    return r;
  endfunction

  function automatic logic [WIDE_W-1:0] pp_sum(input pp_t p);
    return WIDE_W'(p.ll) + (WIDE_W'(p.lh) << SPLIT) + (WIDE_W'(p.hl) << SPLIT)
         + (WIDE_W'(p.hh) << (2 * SPLIT));
  endfunction

  function automatic logic [TIME_W-1:0] sat_time(input logic neg, input logic over,
                                                 input logic [MAGQ_W-1:0] mag);
    logic [TIME_W-1:0] r;
    if (neg) begin
      if (over || mag > MAGQ_W'(TIME_MIN)) r = TIME_MIN;
      else r = -mag[TIME_W-1:0];
    end else begin
      if (over || mag > MAGQ_W'(TIME_MAX)) r = TIME_MAX;
      else r = mag[TIME_W-1:0];
    end
    return r;
  endfunction

  function automatic sq_t sq_step(input sq_t s);
    sq_t               r;
    logic [SREM_W+1:0] cur;
    logic [SREM_W+1:0] trial;
    logic [SREM_W+1:0] diff;
    r     = s;
    cur   = {s.rem, s.rad[RADC_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    diff  = cur - trial;
    r.rad = {s.rad[RADC_W-3:0], 2'b00};
    if (cur >= trial) begin
      r.rem  = diff[SREM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur[SREM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t dv_step(input dv_t s);
    dv_t             r;
    logic [DREM_W:0] cur;
    logic [DREM_W:0] diff;
    logic            ge;
    r     = s;
    cur   = {s.rem, s.nq[DV_N-1]};
    diff  = cur - {1'b0, s.dvdv};
    ge    = cur >= {1'b0, s.dvdv};
    r.rem = ge ? diff[DREM_W-1:0] : cur[DREM_W-1:0];
    r.nq  = {s.nq[DV_N-2:0], ge};
    return r;
  endfunction

  function automatic ax_t ax_step(input ax_t s);
    ax_t             r;
    logic [WDIV_W:0] cur;
    logic [WDIV_W:0] diff;
    logic            ge;
    r     = s;
    cur   = {s.rem, s.nq[WD_N-1]};
    diff  = cur - {1'b0, s.div};
    ge    = cur >= {1'b0, s.div};
    r.rem = ge ? diff[WDIV_W-1:0] : cur[WDIV_W-1:0];
    r.nq  = {s.nq[WD_N-2:0], ge};
    return r;
  endfunction

  function automatic ax_t ax_load(input logic signed [IN_W-1:0] p,
                                  input logic [RAD_W-1:0] rad,
                                  input logic [RAD_W-1:0] size,
                                  input logic signed [IN_W-1:0] v);
    ax_t                      r;
    logic signed [WNUM_W-1:0] num;
    logic [WNUM_W-1:0]        mag;
    if (!v[IN_W-1]) begin
      num = $signed({{(WNUM_W-RAD_W){1'b0}}, size})
          - $signed({{(WNUM_W-IN_W){p[IN_W-1]}}, p})
          - $signed({{(WNUM_W-RAD_W){1'b0}}, rad});
    end else begin
      num = $signed({{(WNUM_W-RAD_W){1'b0}}, rad})
          - $signed({{(WNUM_W-IN_W){p[IN_W-1]}}, p});
    end
    mag   = num[WNUM_W-1] ? WNUM_W'(-num) : WNUM_W'(num);
    r.hit = v != '0;
    r.neg = num[WNUM_W-1] ^ v[IN_W-1];
    r.div = v[IN_W-1] ? WDIV_W'(-v) : WDIV_W'(v);
    r.rem = '0;
    r.nq  = {mag[WMAG_W-1:0], {FRAC_BITS{1'b0}}};
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] ax_time(input ax_t s);
    return s.hit ? sat_time(s.neg && s.nq != '0, 1'b0, MAGQ_W'(s.nq)) : TIME_MAX;
  endfunction

  logic                    accept;
  logic [PIPE_DEPTH-1:0]   vld_q, vld_d;
  logic [RAD_W-1:0]        box_w_q, box_w_d;
  logic [RAD_W-1:0]        box_h_q, box_h_d;

  s1_t                     s1_q, s1_d;
  s2_t                     s2_q, s2_d;
  s3_t                     s3_q, s3_d;
  s4_t                     s4_q, s4_d;
  s5_t                     s5_q, s5_d;
  s6_t                     s6_q, s6_d;
  s7_t                     s7_q, s7_d;
  sq_t                     sq_q [SQ_N+1];
  sq_t                     sq_d [SQ_N+1];
  dv_t                     dv_q [DV_N+1];
  dv_t                     dv_d [DV_N+1];
  logic                    pair_hit_q, pair_hit_d;
  logic [TIME_W-1:0]       pair_time_q, pair_time_d;
  wd_t                     wd_q [WD_N+1];
  wd_t                     wd_d [WD_N+1];
  wo_t                     wl_q [WL_N];
  wo_t                     wl_d [WL_N];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_comb begin
    box_w_d = box_w_q;
    box_h_d = box_h_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BOX_WIDTH:  box_w_d = cfg_data_i[RAD_W-1:0];
        REG_BOX_HEIGHT: box_h_d = cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign vld_d = {vld_q[PIPE_DEPTH-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      box_w_q <= BOX_RESET;
      box_h_q <= BOX_RESET;
    end else begin
      vld_q   <= vld_d;
      box_w_q <= box_w_d;
      box_h_q <= box_h_d;
    end
  end

  // relative motion and products
  always_comb begin
    logic signed [DOT_W-1:0] neg_dot;
    logic [ACC_W-1:0]        dsub;
    s1_d.same = same_particle_i;
    s1_d.dx   = {pos_x_a_i[IN_W-1], pos_x_a_i} - {pos_x_b_i[IN_W-1], pos_x_b_i};
    s1_d.dy   = {pos_y_a_i[IN_W-1], pos_y_a_i} - {pos_y_b_i[IN_W-1], pos_y_b_i};
    s1_d.dvx  = {vel_x_a_i[IN_W-1], vel_x_a_i} - {vel_x_b_i[IN_W-1], vel_x_b_i};
    s1_d.dvy  = {vel_y_a_i[IN_W-1], vel_y_a_i} - {vel_y_b_i[IN_W-1], vel_y_b_i};
    s1_d.sig  = {1'b0, radius_a_i} + {1'b0, radius_b_i};

    s2_d.same = s1_q.same;
    s2_d.rv_x = s1_q.dx * s1_q.dvx;
    s2_d.rv_y = s1_q.dy * s1_q.dvy;
    s2_d.vv_x = SQR_W'(SPROD_W'(s1_q.dvx * s1_q.dvx));
    s2_d.vv_y = SQR_W'(SPROD_W'(s1_q.dvy * s1_q.dvy));
    s2_d.rr_x = SQR_W'(SPROD_W'(s1_q.dx * s1_q.dx));
    s2_d.rr_y = SQR_W'(SPROD_W'(s1_q.dy * s1_q.dy));
    s2_d.ss   = SS_W'(s1_q.sig) * SS_W'(s1_q.sig);

    s3_d.nohit = s2_q.same;
    s3_d.dvdr  = {s2_q.rv_x[SPROD_W-1], s2_q.rv_x} + {s2_q.rv_y[SPROD_W-1], s2_q.rv_y};
    s3_d.dvdv  = {1'b0, s2_q.vv_x} + {1'b0, s2_q.vv_y};
    s3_d.drdr  = {1'b0, s2_q.rr_x} + {1'b0, s2_q.rr_y};
    s3_d.ss    = s2_q.ss;

    neg_dot    = -s3_q.dvdr;
    s4_d.nohit = s3_q.nohit || (!s3_q.dvdr[DOT_W-1] && s3_q.dvdr != '0)
              || (s3_q.dvdv == '0);
    s4_d.mdr   = neg_dot[MAG_W-1:0];
    s4_d.dvdv  = s3_q.dvdv;
    s4_d.drdr  = s3_q.drdr;
    s4_d.ss    = s3_q.ss;

    s5_d.nohit = s4_q.nohit;
    s5_d.mdr   = s4_q.mdr;
    s5_d.dvdv  = s4_q.dvdv;
    s5_d.pa    = pp_mul(s4_q.mdr, s4_q.mdr);
    s5_d.pb    = pp_mul(s4_q.dvdv, MAG_W'(s4_q.ss));
    s5_d.pc    = pp_mul(s4_q.dvdv, s4_q.drdr);

    s6_d.nohit = s5_q.nohit;
    s6_d.mdr   = s5_q.mdr;
    s6_d.dvdv  = s5_q.dvdv;
    s6_d.pa    = pp_sum(s5_q.pa);
    s6_d.pb    = pp_sum(s5_q.pb);
    s6_d.pc    = pp_sum(s5_q.pc);

    s7_d.nohit = s6_q.nohit;
    s7_d.mdr   = s6_q.mdr;
    s7_d.dvdv  = s6_q.dvdv;
    s7_d.a     = {1'b0, s6_q.pa} + {1'b0, s6_q.pb};
    s7_d.b     = s6_q.pc;

    dsub             = s7_q.a - {1'b0, s7_q.b};
    sq_d[0].nohit    = s7_q.nohit || (s7_q.a < {1'b0, s7_q.b});
    sq_d[0].mdr      = s7_q.mdr;
    sq_d[0].dvdv     = s7_q.dvdv;
    sq_d[0].rem      = '0;
    sq_d[0].root     = '0;
    sq_d[0].rad      = {1'b0, dsub};

    // square root, two radicand bits per stage
    for (int k = 1; k <= SQ_N; k++) begin
      sq_d[k] = sq_step(sq_q[k-1]);
    end
  end

  // numerator and divider, one quotient bit per stage
  always_comb begin
    logic [ROOT_W-1:0] mdr_x;
    logic              ge;
    logic [ROOT_W-1:0] num;
    mdr_x          = {1'b0, sq_q[SQ_N].mdr};
    ge             = mdr_x >= sq_q[SQ_N].root;
    num            = ge ? mdr_x - sq_q[SQ_N].root : sq_q[SQ_N].root - mdr_x;
    dv_d[0].nohit  = sq_q[SQ_N].nohit;
    dv_d[0].nneg   = !ge;
    dv_d[0].dvdv   = sq_q[SQ_N].dvdv;
    dv_d[0].rem    = '0;
    dv_d[0].nq     = {num, {FRAC_BITS{1'b0}}};
    for (int k = 1; k <= DV_N; k++) begin
      dv_d[k] = dv_step(dv_q[k-1]);
    end
  end

  always_comb begin
    logic over;
    over        = |dv_q[DV_N].nq[DV_N-1:MAGQ_W];
    pair_hit_d  = !dv_q[DV_N].nohit;
    pair_time_d = dv_q[DV_N].nohit ? TIME_MAX
                : sat_time(dv_q[DV_N].nneg, over, dv_q[DV_N].nq[MAGQ_W-1:0]);
  end

  // wall times, then delay to line up with the pair result
  always_comb begin
    wd_d[0].x = ax_load(pos_x_a_i, radius_a_i, box_w_q, vel_x_a_i);
    wd_d[0].y = ax_load(pos_y_a_i, radius_a_i, box_h_q, vel_y_a_i);
    for (int k = 1; k <= WD_N; k++) begin
      wd_d[k].x = ax_step(wd_q[k-1].x);
      wd_d[k].y = ax_step(wd_q[k-1].y);
    end
    wl_d[0].xhit  = wd_q[WD_N].x.hit;
    wl_d[0].xtime = ax_time(wd_q[WD_N].x);
    wl_d[0].yhit  = wd_q[WD_N].y.hit;
    wl_d[0].ytime = ax_time(wd_q[WD_N].y);
    for (int k = 1; k < WL_N; k++) begin
      wl_d[k] = wl_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q        <= s1_d;
    s2_q        <= s2_d;
    s3_q        <= s3_d;
    s4_q        <= s4_d;
    s5_q        <= s5_d;
    s6_q        <= s6_d;
    s7_q        <= s7_d;
    pair_hit_q  <= pair_hit_d;
    pair_time_q <= pair_time_d;
    for (int k = 0; k <= SQ_N; k++) sq_q[k] <= sq_d[k];
    for (int k = 0; k <= DV_N; k++) dv_q[k] <= dv_d[k];
    for (int k = 0; k <= WD_N; k++) wd_q[k] <= wd_d[k];
    for (int k = 0; k < WL_N; k++) wl_q[k] <= wl_d[k];
  end

  assign result_valid_o = vld_q[PIPE_DEPTH-1];
  assign pair_hit_o     = pair_hit_q;
  assign pair_time_o    = pair_time_q;
  assign vwall_hit_o    = wl_q[WL_N-1].xhit;
  assign vwall_time_o   = wl_q[WL_N-1].xtime;
  assign hwall_hit_o    = wl_q[WL_N-1].yhit;
  assign hwall_time_o   = wl_q[WL_N-1].ytime;

endmodule

// ===== sv/ctp_checker.sv =====
`timescale 1ns / 1ps
`include "collision_time_predictor_defines.svh"

module ctp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              same_particle_i,
  input logic signed [ctp_pkg::IN_W-1:0]   vel_x_a_i,
  input logic                              result_valid_o,
  input logic                              pair_hit_o,
  input logic signed [ctp_pkg::TIME_W-1:0] pair_time_o,
  input logic                              vwall_hit_o
);
  import ctp_pkg::*;

  `CTP_ASSERT_LATER(a_latency, clk_i, rst_ni, start && !busy, PIPE_DEPTH, result_valid_o, "result beat missing")
  `CTP_ASSERT_LATER(a_same_nohit, clk_i, rst_ni, start && !busy && same_particle_i, PIPE_DEPTH, !pair_hit_o, "same disk reported a hit")
  `CTP_ASSERT_LATER(a_still_nowall, clk_i, rst_ni, start && !busy && vel_x_a_i == '0, PIPE_DEPTH, !vwall_hit_o, "wall hit with zero velocity")
  `CTP_ASSERT(a_nohit_inf, clk_i, rst_ni, result_valid_o && !pair_hit_o |-> pair_time_o == TIME_MAX, "no hit without infinite time")

endmodule

bind collision_time_predictor ctp_checker u_ctp_checker (.*);

// ===== sim/tb_collision_time_predictor.sv =====
`timescale 1ns / 1ps

module tb_collision_time_predictor;
  import ctp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_BOX_HEIGHT) + 1'b1;
  localparam int DRAIN_CYCLES = PIPE_DEPTH + 20;

  typedef struct {
    logic                    same;
    logic signed [IN_W-1:0]  pxa, pya, vxa, vya;
    logic [RAD_W-1:0]        ra;
    logic signed [IN_W-1:0]  pxb, pyb, vxb, vyb;
    logic [RAD_W-1:0]        rb;
  } pair_item_t;

  typedef struct {
    logic                     pair_hit;
    logic signed [TIME_W-1:0] pair_time;
    logic                     vwall_hit;
    logic signed [TIME_W-1:0] vwall_time;
    logic                     hwall_hit;
    logic signed [TIME_W-1:0] hwall_time;
  } eta_t;

  typedef struct {
    pair_item_t item;
    logic       typed;
    eta_t       eta;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  pair_item_t drv = '{default: '0};
  logic result_valid_o, pair_hit_o, vwall_hit_o, hwall_hit_o;
  logic signed [TIME_W-1:0] pair_time_o, vwall_time_o, hwall_time_o;

  logic [RAD_W-1:0] box_w = BOX_RESET;
  logic [RAD_W-1:0] box_h = BOX_RESET;
  eta_t eta_q[$];
  int errors = 0;
  int accepts = 0;
  int cfg_writes = 0;
  logic typed_now = 1'b0;
  eta_t typed_eta;
  bit no_gaps = 0;

  always #6 clk_i = ~clk_i;

  collision_time_predictor dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .same_particle_i(drv.same),
    .pos_x_a_i(drv.pxa), .pos_y_a_i(drv.pya), .vel_x_a_i(drv.vxa), .vel_y_a_i(drv.vya),
    .radius_a_i(drv.ra),
    .pos_x_b_i(drv.pxb), .pos_y_b_i(drv.pyb), .vel_x_b_i(drv.vxb), .vel_y_b_i(drv.vyb),
    .radius_b_i(drv.rb),
    .result_valid_o, .pair_hit_o, .pair_time_o, .vwall_hit_o, .vwall_time_o,
    .hwall_hit_o, .hwall_time_o
  );

  function automatic logic [TIME_W-1:0] clamp_time(logic neg, logic [199:0] mag);
    if (neg) return (mag > 200'(TIME_MAX) + 1) ? TIME_MIN : -mag[TIME_W-1:0];
    return (mag > 200'(TIME_MAX)) ? TIME_MAX : mag[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] wall_eta(longint p, longint rad, longint size,
                                                  longint v);
    longint num;
    logic [199:0] mag;
    num = (v > 0) ? size - p - rad : rad - p;
    mag = ((200'(num < 0 ? -num : num)) << FRAC_BITS) / 200'(v < 0 ? -v : v);
    return clamp_time(((num < 0) != (v < 0)) && mag != 0, mag);
  endfunction

  function automatic eta_t predict_eta(pair_item_t it, logic [RAD_W-1:0] bw,
                                       logic [RAD_W-1:0] bh);
    logic signed [199:0] dx, dy, dvx, dvy, dvdr;
    logic [199:0] mdr, dvdv, drdr, sig, lhs, rhs, disc, root, cand, num, quo;
    logic nneg;
    eta_t r;
    dx = it.pxa; dx = dx - it.pxb;
    dy = it.pya; dy = dy - it.pyb;
    dvx = it.vxa; dvx = dvx - it.vxb;
    dvy = it.vya; dvy = dvy - it.vyb;
    dvdr = dx * dvx + dy * dvy;
    r.pair_hit = 1'b0;
    r.pair_time = TIME_MAX;
    if (!it.same && dvdr <= 0) begin
      mdr = -dvdr;
      dvdv = dvx * dvx + dvy * dvy;
      drdr = dx * dx + dy * dy;
      sig = 200'(it.ra) + 200'(it.rb);
      lhs = mdr * mdr + dvdv * sig * sig;
      rhs = dvdv * drdr;
      if (dvdv != 0 && lhs >= rhs) begin
        disc = lhs - rhs;
        root = '0;
        for (int i = 66; i >= 0; i--) begin
          cand = root | (200'(1) << i);
          if (cand * cand <= disc) root = cand;
        end
        nneg = root > mdr;
        num = nneg ? root - mdr : mdr - root;
        quo = (num << FRAC_BITS) / dvdv;
        r.pair_hit = 1'b1;
        r.pair_time = clamp_time(nneg, quo);
      end
    end
    r.vwall_hit = it.vxa != 0;
    r.vwall_time = r.vwall_hit ? wall_eta(it.pxa, it.ra, bw, it.vxa) : TIME_MAX;
    r.hwall_hit = it.vya != 0;
    r.hwall_time = r.hwall_hit ? wall_eta(it.pya, it.ra, bh, it.vya) : TIME_MAX;
    return r;
  endfunction

  // accepted beats, config writes and result checks
  always @(posedge clk_i) begin
    eta_t e;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_BOX_WIDTH) box_w = cfg_data_i[RAD_W-1:0];
        else if (cfg_index_i == REG_BOX_HEIGHT) box_h = cfg_data_i[RAD_W-1:0];
        cfg_writes++;
      end
      if (start && !busy) begin
        eta_q.push_back(typed_now ? typed_eta : predict_eta(drv, box_w, box_h));
        accepts++;
      end
      if (result_valid_o) begin
        if (eta_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = eta_q.pop_front();
          if (pair_hit_o !== e.pair_hit) begin
            $error("pair_hit exp %0d got %0d", e.pair_hit, pair_hit_o); errors++;
          end
          if (pair_time_o !== e.pair_time) begin
            $error("pair_time exp %0d got %0d", e.pair_time, pair_time_o); errors++;
          end
          if (vwall_hit_o !== e.vwall_hit) begin
            $error("vwall_hit exp %0d got %0d", e.vwall_hit, vwall_hit_o); errors++;
          end
          if (vwall_time_o !== e.vwall_time) begin
            $error("vwall_time exp %0d got %0d", e.vwall_time, vwall_time_o); errors++;
          end
          if (hwall_hit_o !== e.hwall_hit) begin
            $error("hwall_hit exp %0d got %0d", e.hwall_hit, hwall_hit_o); errors++;
          end
          if (hwall_time_o !== e.hwall_time) begin
            $error("hwall_time exp %0d got %0d", e.hwall_time, hwall_time_o); errors++;
          end
        end
      end
    end
  end

  task automatic send_pair(pair_item_t it, logic typed, eta_t e);
    int n0;
    while (!no_gaps && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    typed_now = typed;
    typed_eta = e;
    n0 = accepts;
    start <= 1'b1;
    drv <= it;
    wait (accepts != n0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int n0;
    n0 = cfg_writes;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    wait (cfg_writes != n0);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (eta_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic pair_item_t wide_pair();
    pair_item_t it;
    it.same = $urandom_range(7) == 0;
    it.pxa = $urandom(); it.pya = $urandom(); it.vxa = $urandom(); it.vya = $urandom();
    it.pxb = $urandom(); it.pyb = $urandom(); it.vxb = $urandom(); it.vyb = $urandom();
    it.ra = RAD_W'($urandom()); it.rb = RAD_W'($urandom());
    if ($urandom_range(3) == 0) it.vxa = '0;
    if ($urandom_range(3) == 0) it.vya = '0;
    return it;
  endfunction

  // disks inside the box, mostly heading toward each other
  function automatic pair_item_t box_pair();
    pair_item_t it;
    it.same = $urandom_range(19) == 0;
    it.pxa = $urandom_range(900 << 16);
    it.pya = $urandom_range(900 << 16);
    it.pxb = it.pxa + int'($urandom_range(160 << 16)) - (80 << 16);
    it.pyb = it.pya + int'($urandom_range(160 << 16)) - (80 << 16);
    it.vxa = int'($urandom_range(400 << 16)) - (200 << 16);
    it.vya = int'($urandom_range(400 << 16)) - (200 << 16);
    it.ra = RAD_W'($urandom_range(30 << 16));
    it.rb = RAD_W'($urandom_range(30 << 16));
    if ($urandom_range(3) != 0) begin
      it.vxb = it.vxa + (it.pxa - it.pxb) / int'($urandom_range(8, 1));
      it.vyb = it.vya + (it.pya - it.pyb) / int'($urandom_range(8, 1));
    end else begin
      it.vxb = int'($urandom_range(400 << 16)) - (200 << 16);
      it.vyb = int'($urandom_range(400 << 16)) - (200 << 16);
    end
    if ($urandom_range(15) == 0) begin
      it.vxb = it.vxa; it.vyb = it.vya;
    end
    if ($urandom_range(11) == 0) it.vxa = '0;
    if ($urandom_range(11) == 0) it.vya = '0;
    return it;
  endfunction

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    eta_t none;
    pair_item_t z;
    logic [CFG_DATA_W-1:0] boxes[6];
    none = '{1'b0, TIME_MAX, 1'b0, TIME_MAX, 1'b0, TIME_MAX};
    z = '{default: '0};
    boxes = '{32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'(100 << 16), 32'h8000_0000,
              32'(2000 << 16)};

    // directed rows
    rw = '{z, 1'b1, none}; rows.push_back(rw);
    rw.item.same = 1'b1; rows.push_back(rw);
    rw = '{z, 1'b0, none};
    rw.item.pxb = 32'(10 << 16); rw.item.vxb = -32'(1 << 16);
    rw.item.ra = 31'(1 << 16); rw.item.rb = 31'(1 << 16);
    rows.push_back(rw);
    rw.item.same = 1'b1; rows.push_back(rw);
    rw.item.same = 1'b0; rw.item.vxb = 32'(1 << 16); rows.push_back(rw);
    rw.item.pyb = 32'(50 << 16); rw.item.vxb = -32'(1 << 16); rows.push_back(rw);
    rw.item.pxb = 32'(1 << 16); rw.item.pyb = '0; rows.push_back(rw);
    rw = '{z, 1'b0, none};
    rw.item.pxa = 32'h7FFF_FFFF; rw.item.pya = 32'h8000_0000;
    rw.item.vxa = 32'h7FFF_FFFF; rw.item.vya = 32'h8000_0000;
    rw.item.pxb = 32'h8000_0000; rw.item.pyb = 32'h7FFF_FFFF;
    rw.item.vxb = 32'h8000_0000; rw.item.vyb = 32'h7FFF_FFFF;
    rw.item.ra = '1; rw.item.rb = '1;
    rows.push_back(rw);
    rw.item.vxa = 32'h8000_0000; rw.item.vya = 32'h7FFF_FFFF;
    rw.item.vxb = 32'h7FFF_FFFF; rw.item.vyb = 32'h8000_0000;
    rows.push_back(rw);
    rw.item.ra = '0; rw.item.rb = '0; rows.push_back(rw);
    rw = '{z, 1'b0, none};
    rw.item.vxa = 32'd1; rw.item.vya = -32'd1; rw.item.pxa = 32'h7FFF_FFFF;
    rw.item.pya = 32'h7FFF_FFFF; rows.push_back(rw);
    rw.item.vxa = -32'd1; rw.item.vya = 32'd1; rw.item.pxa = 32'h8000_0000;
    rw.item.pya = 32'h8000_0000; rows.push_back(rw);
    rw = '{z, 1'b0, none};
    rw.item.pxa = 32'(100 << 16); rw.item.pya = 32'(100 << 16);
    rw.item.vxa = 32'(3 << 16); rw.item.vya = -32'(7 << 16); rw.item.ra = 31'(5 << 16);
    rw.item.pxb = 32'(104 << 16); rw.item.pyb = 32'(101 << 16);
    rw.item.rb = 31'(5 << 16); rows.push_back(rw);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_pair(rows[i].item, rows[i].typed, rows[i].eta);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        write_reg(REG_BOX_WIDTH, boxes[$urandom_range(5)]);
        write_reg(REG_BOX_HEIGHT, boxes[$urandom_range(5)]);
        if (ph == 3) write_reg(REG_SPARE, 32'h0000_1234);
        if (ph == 1) write_reg(REG_BOX_WIDTH, 32'h7FFF_FFFF);
        if (ph == 2) write_reg(REG_BOX_HEIGHT, 32'h0);
      end
      no_gaps = (ph == 4);
      for (int n = 0; n < 240; n++)
        send_pair(($urandom_range(9) < 7) ? box_pair() : wide_pair(), 1'b0, none);
      drain();
    end

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ctp_pkg.sv
sv/collision_time_predictor.sv
sv/ctp_checker.sv
sim/tb_collision_time_predictor.sv
